// ----- hdl/mst_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the timer slot unit.
package mst_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int FUNC_W        = 2;
  localparam int SLOT_W        = 8;
  localparam int TASK_W        = 16;
  localparam int TIME_W        = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  // Operation codes carried in the func field
  localparam logic [FUNC_W-1:0] FUNC_SCHED  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_EXEC   = 2'd3;

  // Scan index control
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_SLOT,
    IDX_INC
  } idx_op_t;

  // Slot write-back kind
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_CANCEL,
    WR_TICK,
    WR_EXEC
  } wr_op_t;

  // Result word to load into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FINAL,
    EMIT_MID,
    EMIT_LAST
  } emit_t;

  typedef struct packed {
    logic    take;
    idx_op_t idx_op;
    wr_op_t  wr_op;
    logic    tick_fin;
    emit_t   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              reject;
    logic              ticking;
    logic              out_free;
    logic              idx_last;
    logic              tgt_active;
    logic              match;
    logic              cur_ready;
    logic              pend_v;
    logic              cnt_last;
  } dp_stat_t;

endpackage

// ----- hdl/mst_in_if.sv -----
// Request channel: one operation word per handshake.
interface mst_in_if;
  logic                            valid;
  logic                            ready;
  logic [mst_pkg::FUNC_W-1:0]      func;
  logic [mst_pkg::SLOT_W-1:0]      slot;
  logic [mst_pkg::TASK_W-1:0]      task_id;
  logic [mst_pkg::TIME_W-1:0]      time_ms;

  modport source (output valid, output func, output slot, output task_id, output time_ms,
                  input ready);
  modport sink (input valid, input func, input slot, input task_id, input time_ms,
                output ready);
endinterface

// ----- hdl/mst_out_if.sv -----
// Result channel: one result word per handshake.
interface mst_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [mst_pkg::SLOT_W-1:0]      slot_out;
  logic [mst_pkg::TASK_W-1:0]      ready_task;
  logic                            run_valid;
  logic                            last;
  logic                            running;

  modport source (output valid, output status, output slot_out, output ready_task,
                  output run_valid, output last, output running, input ready);
  modport sink (input valid, input status, input slot_out, input ready_task,
                input run_valid, input last, input running, output ready);
endinterface

// ----- hdl/mst_datapath.sv -----
// Datapath: slot memory, ready and valid flags, scan index, item latch and output register.
module mst_datapath #(
  parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mst_pkg::dp_cmd_t            cmd,
  output mst_pkg::dp_stat_t           stat,
  input  logic [mst_pkg::FUNC_W-1:0]  in_func,
  input  logic [mst_pkg::SLOT_W-1:0]  in_slot,
  input  logic [mst_pkg::TASK_W-1:0]  in_task_id,
  input  logic [mst_pkg::TIME_W-1:0]  in_time_ms,
  mst_out_if.source                   rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [mst_pkg::TIME_W-1:0] tmo;
    logic [mst_pkg::TIME_W-1:0] ela;
    logic [mst_pkg::TASK_W-1:0] task_id;
  } slot_word_t;

  // Item latch
  logic [mst_pkg::FUNC_W-1:0] it_func;
  logic [mst_pkg::SLOT_W-1:0] it_slot;
  logic [mst_pkg::TASK_W-1:0] it_id;
  logic [mst_pkg::TIME_W-1:0] it_tms;

  // Slot state
  slot_word_t                 mem [SLOTS];
  slot_word_t                 rd_word;
  logic                       rd_vld;
  logic [SLOTS-1:0]           valid;
  logic [SLOTS-1:0]           ready;
  logic                       ticking;

  // Scan state
  logic [AW-1:0]              idx;
  logic                       found;
  logic                       active_seen;
  logic [mst_pkg::CNT_W-1:0]  nfound;
  logic                       pend_v;
  logic [AW-1:0]              pend_slot;
  logic [mst_pkg::TASK_W-1:0] pend_task;

  // Output register
  logic                       out_v;
  logic                       out_status;
  logic [mst_pkg::SLOT_W-1:0] out_slot;
  logic [mst_pkg::TASK_W-1:0] out_task;
  logic                       out_run;
  logic                       out_last;
  logic                       out_running;

  slot_word_t                 cur;
  logic                       cur_active;
  logic [mst_pkg::TIME_W-1:0] ela_inc;
  logic                       expire;
  logic                       reject;
  logic                       out_free;
  logic                       wr_en;
  slot_word_t                 wr_word;

  // Never-written slots read as zero
  assign cur        = rd_vld ? rd_word : '0;
  assign cur_active = (cur.tmo != '0);
  assign ela_inc    = cur.ela + mst_pkg::TIME_W'(1);
  assign expire     = (ela_inc >= cur.tmo);
  assign reject     = (it_slot >= mst_pkg::SLOT_W'(SLOTS));
  assign out_free   = !out_v || rsp.ready;

  always_comb begin
    stat.func       = it_func;
    stat.reject     = reject;
    stat.ticking    = ticking;
    stat.out_free   = out_free;
    stat.idx_last   = (idx == AW'(SLOTS - 1));
    stat.tgt_active = cur_active;
    stat.match      = (cur.task_id == it_id);
    stat.cur_ready  = ready[idx];
    stat.pend_v     = pend_v;
    stat.cnt_last   = (nfound == mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS - 1));
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_func <= in_func;
      it_slot <= in_slot;
      it_id   <= in_task_id;
      it_tms  <= in_time_ms;
    end
  end

  // Advance the scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (cmd.idx_op)
        mst_pkg::IDX_ZERO: idx <= '0;
        mst_pkg::IDX_SLOT: idx <= it_slot[AW-1:0];
        mst_pkg::IDX_INC:  idx <= idx + AW'(1);
        default:           idx <= idx;
      endcase
    end
  end

  // Build the write-back word for the slot under the index
  always_comb begin
    wr_en   = 1'b0;
    wr_word = cur;
    case (cmd.wr_op)
      mst_pkg::WR_LOAD: begin
        wr_en   = 1'b1;
        wr_word = '{tmo: it_tms, ela: '0, task_id: it_id};
      end
      mst_pkg::WR_CANCEL: begin
        wr_en       = 1'b1;
        wr_word.tmo = '0;
      end
      mst_pkg::WR_TICK: begin
        wr_en       = cur_active;
        wr_word.ela = ela_inc;
        if (expire) begin
          wr_word.tmo = '0;
        end
      end
      mst_pkg::WR_EXEC: begin
        wr_en       = 1'b1;
        wr_word.tmo = '0;
        wr_word.ela = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Slot memory: one write and one registered read at the index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_word;
    end
    rd_word <= mem[idx];
    rd_vld  <= valid[idx];
  end

  // Hold valid, ready and the tick enable
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      ready   <= '0;
      ticking <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[idx] <= 1'b1;
      end
      case (cmd.wr_op)
        mst_pkg::WR_CANCEL: ready[idx] <= 1'b0;
        mst_pkg::WR_EXEC:   ready[idx] <= 1'b0;
        mst_pkg::WR_TICK: begin
          if (cur_active && expire) begin
            ready[idx] <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.wr_op == mst_pkg::WR_LOAD) begin
        ticking <= 1'b1;
      end else if (cmd.tick_fin) begin
        ticking <= active_seen || cur_active;
      end
    end
  end

  // Track scan results
  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      active_seen <= 1'b0;
      nfound      <= '0;
      pend_v      <= 1'b0;
    end else if (cmd.take) begin
      found       <= 1'b0;
      active_seen <= 1'b0;
      nfound      <= '0;
      pend_v      <= 1'b0;
    end else begin
      if (cmd.wr_op == mst_pkg::WR_CANCEL) begin
        found <= 1'b1;
      end
      if (cmd.wr_op == mst_pkg::WR_TICK && cur_active) begin
        active_seen <= 1'b1;
      end
      if (cmd.wr_op == mst_pkg::WR_EXEC) begin
        nfound <= nfound + mst_pkg::CNT_W'(1);
        pend_v <= 1'b1;
      end
    end
  end

  // Hold the run waiting to be reported
  always_ff @(posedge clk) begin
    if (cmd.wr_op == mst_pkg::WR_EXEC) begin
      pend_slot <= idx;
      pend_task <= cur.task_id;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.emit != mst_pkg::EMIT_NONE) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      mst_pkg::EMIT_FINAL: begin
        out_status  <= ((it_func == mst_pkg::FUNC_SCHED) && reject) ||
                       ((it_func == mst_pkg::FUNC_CANCEL) && !found);
        out_slot    <= ((it_func == mst_pkg::FUNC_SCHED) && !reject) ? it_slot : '0;
        out_task    <= '0;
        out_run     <= 1'b0;
        out_last    <= 1'b1;
        out_running <= ticking;
      end
      mst_pkg::EMIT_MID, mst_pkg::EMIT_LAST: begin
        out_status  <= 1'b0;
        out_slot    <= mst_pkg::SLOT_W'(pend_slot);
        out_task    <= pend_task;
        out_run     <= 1'b1;
        out_last    <= (cmd.emit == mst_pkg::EMIT_LAST);
        out_running <= ticking;
      end
      default: ;
    endcase
  end

  assign rsp.valid      = out_v;
  assign rsp.status     = out_status;
  assign rsp.slot_out   = out_slot;
  assign rsp.ready_task = out_task;
  assign rsp.run_valid  = out_run;
  assign rsp.last       = out_last;
  assign rsp.running    = out_running;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    nfound <= mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS))
    else $error("run count passed the per-word limit");

  a_load_on: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_op == mst_pkg::WR_LOAD) |=> ticking)
    else $error("schedule did not switch ticking on");

  a_tick_off: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick_fin && !active_seen && !cur_active) |=> !ticking)
    else $error("tick with no active slot left ticking on");

endmodule

// ----- hdl/mst_ctrl.sv -----
// Controller: sequences schedule, cancel, tick and execute scans over the slots.
module mst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output mst_pkg::dp_cmd_t  cmd,
  input  mst_pkg::dp_stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SEV   = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CEV   = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_TRD   = 4'd7;
  localparam logic [3:0] S_TEV   = 4'd8;
  localparam logic [3:0] S_XRD   = 4'd9;
  localparam logic [3:0] S_XEV   = 4'd10;
  localparam logic [3:0] S_XFIN  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    cmd.take     = 1'b0;
    cmd.idx_op   = mst_pkg::IDX_HOLD;
    cmd.wr_op    = mst_pkg::WR_NONE;
    cmd.tick_fin = 1'b0;
    cmd.emit     = mst_pkg::EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (stat.func)
          mst_pkg::FUNC_SCHED: begin
            if (stat.reject) begin
              state_next = S_EMIT;
            end else begin
              cmd.idx_op = mst_pkg::IDX_SLOT;
              state_next = S_SRD;
            end
          end
          mst_pkg::FUNC_CANCEL: begin
            cmd.idx_op = mst_pkg::IDX_ZERO;
            state_next = S_CRD;
          end
          mst_pkg::FUNC_TICK: begin
            if (stat.ticking) begin
              cmd.idx_op = mst_pkg::IDX_ZERO;
              state_next = S_TRD;
            end else begin
              state_next = S_EMIT;
            end
          end
          default: begin
            cmd.idx_op = mst_pkg::IDX_ZERO;
            state_next = S_XRD;
          end
        endcase
      end
      S_SRD: state_next = S_SEV;
      // Busy target: cancel the lowest holder of the id first
      S_SEV: begin
        if (stat.tgt_active) begin
          cmd.idx_op = mst_pkg::IDX_ZERO;
          state_next = S_CRD;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_CRD: state_next = S_CEV;
      S_CEV: begin
        if (stat.match || stat.idx_last) begin
          if (stat.match) begin
            cmd.wr_op = mst_pkg::WR_CANCEL;
          end
          if (stat.func == mst_pkg::FUNC_SCHED) begin
            cmd.idx_op = mst_pkg::IDX_SLOT;
            state_next = S_LOAD;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          cmd.idx_op = mst_pkg::IDX_INC;
          state_next = S_CRD;
        end
      end
      S_LOAD: begin
        cmd.wr_op  = mst_pkg::WR_LOAD;
        state_next = S_EMIT;
      end
      S_TRD: state_next = S_TEV;
      S_TEV: begin
        cmd.wr_op = mst_pkg::WR_TICK;
        if (stat.idx_last) begin
          cmd.tick_fin = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.idx_op = mst_pkg::IDX_INC;
          state_next = S_TRD;
        end
      end
      S_XRD: state_next = S_XEV;
      // Report the previous run while taking the next one
      S_XEV: begin
        if (stat.cur_ready && stat.pend_v && !stat.out_free) begin
          state_next = S_XEV;
        end else begin
          if (stat.cur_ready) begin
            cmd.wr_op = mst_pkg::WR_EXEC;
            if (stat.pend_v) begin
              cmd.emit = mst_pkg::EMIT_MID;
            end
          end
          if (stat.idx_last || (stat.cur_ready && stat.cnt_last)) begin
            state_next = S_XFIN;
          end else begin
            cmd.idx_op = mst_pkg::IDX_INC;
            state_next = S_XRD;
          end
        end
      end
      S_XFIN: begin
        if (stat.out_free) begin
          cmd.emit   = stat.pend_v ? mst_pkg::EMIT_LAST : mst_pkg::EMIT_FINAL;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = mst_pkg::EMIT_FINAL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_take_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_START))
    else $error("accepted word did not start an operation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != mst_pkg::EMIT_NONE) |-> stat.out_free)
    else $error("result word loaded over one not yet taken");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (cmd.emit == mst_pkg::EMIT_NONE && cmd.wr_op == mst_pkg::WR_NONE))
    else $error("slot or output activity while idle");

endmodule

// ----- hdl/multi_slot_oneshot_timer_unit.sv -----
// Top level of the one-shot timer slot bank.
//
// Usage: operation words enter on req (valid/ready); result words leave on rsp
// (valid/ready). func selects schedule, cancel, tick or execute. Schedule,
// cancel and tick give one result word each; execute gives one word per ready
// slot, lowest slot first, at most eight, with last set on the final one (one
// empty word with last set when none is ready).
// Timing: one word is handled at a time; req.ready is high only while idle.
// Each slot visit is a memory read state followed by an evaluate state, since
// the single-port slot memory gives a registered read. A rejected schedule or a
// tick while off visits no slot; cancel, tick and execute scan from slot zero;
// a schedule into a busy slot first scans for the id to cancel.
// Reset clears all slots, the ready and valid flags, ticking and the output
// register; the block accepts words on the first cycle after reset.
// Stalls: a result word waits in the output register while rsp.ready is low;
// the scan holds until the register frees, so no word is lost.
module multi_slot_oneshot_timer_unit #(
  parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  mst_in_if.sink    req,
  mst_out_if.source rsp
);

  mst_pkg::dp_cmd_t  cmd;
  mst_pkg::dp_stat_t stat;
  logic              in_ready;

  assign req.ready = in_ready;

  mst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (req.func),
    .in_slot    (req.slot),
    .in_task_id (req.task_id),
    .in_time_ms (req.time_ms),
    .rsp        (rsp)
  );

endmodule
